// File: hdl/pera_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pera_pkg: shared types and constants
// word layouts, op and status codes, prime table and controller interface
// -----------------------------------------------------------------------------
package pera_pkg;

   localparam int OP_WIDTH      = 3;
   localparam int VALUE_WIDTH   = 11;
   localparam int POWER_WIDTH   = 16;
   localparam int EXP_WIDTH     = 32;
   localparam int MAX_VALUE     = 1024;
   localparam int PRIME_SLOTS   = 172;
   localparam int SLOT_WIDTH    = $clog2(PRIME_SLOTS);
   localparam int COUNT_WIDTH   = $clog2(PRIME_SLOTS + 1);
   localparam int M_WIDTH       = VALUE_WIDTH;
   localparam int DELTA_WIDTH   = M_WIDTH + POWER_WIDTH;
   localparam int REM_WIDTH     = VALUE_WIDTH - 1;
   localparam int DIV_STEPS     = VALUE_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_MUL      = 3'd0,
      OP_DIV      = 3'd1,
      OP_MUL_FACT = 3'd2,
      OP_DIV_FACT = 3'd3,
      OP_CLEAR    = 3'd4,
      OP_READ     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BOUND   = 2'd1,
      ST_IGNORED = 2'd2,
      ST_SAT     = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]    op;
      logic [VALUE_WIDTH-1:0] value;
      logic [POWER_WIDTH-1:0] power;
   } req_word_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] prime;
      logic signed [31:0]     net_exponent;
      logic                   is_zero;
      logic [1:0]             status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PRIME,
      S_DIV,
      S_ACC,
      S_ACC_WR,
      S_READ,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_VALUE,
      SRC_WORK,
      SRC_QUOT
   } div_src_type;

   typedef struct packed {
      logic           load_item;
      logic           item_start;
      logic           clear_store;
      logic           set_zero;
      logic           clear_zero;
      logic           status_load;
      rsp_status_type status_code;
      logic           div_start;
      div_src_type    div_src;
      logic           div_take;
      logic           acc_read;
      logic           acc_write;
      logic           next_prime;
      logic           read_issue;
      logic           out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic zero_flag;
      logic power_zero;
      logic value_zero;
      logic over_bound;
      logic read_in_range;
      logic slot_end;
      logic work_le1;
      logic prime_gt_value;
      logic div_done;
      logic rem_zero;
      logic quot_ge_p;
      logic m_zero;
      logic out_free;
   } dp_stat_type;

   localparam logic [VALUE_WIDTH-1:0] PRIME_TABLE [PRIME_SLOTS] = '{
      11'd2,    11'd3,    11'd5,    11'd7,    11'd11,   11'd13,   11'd17,   11'd19,
      11'd23,   11'd29,   11'd31,   11'd37,   11'd41,   11'd43,   11'd47,   11'd53,
      11'd59,   11'd61,   11'd67,   11'd71,   11'd73,   11'd79,   11'd83,   11'd89,
      11'd97,   11'd101,  11'd103,  11'd107,  11'd109,  11'd113,  11'd127,  11'd131,
      11'd137,  11'd139,  11'd149,  11'd151,  11'd157,  11'd163,  11'd167,  11'd173,
      11'd179,  11'd181,  11'd191,  11'd193,  11'd197,  11'd199,  11'd211,  11'd223,
      11'd227,  11'd229,  11'd233,  11'd239,  11'd241,  11'd251,  11'd257,  11'd263,
      11'd269,  11'd271,  11'd277,  11'd281,  11'd283,  11'd293,  11'd307,  11'd311,
      11'd313,  11'd317,  11'd331,  11'd337,  11'd347,  11'd349,  11'd353,  11'd359,
      11'd367,  11'd373,  11'd379,  11'd383,  11'd389,  11'd397,  11'd401,  11'd409,
      11'd419,  11'd421,  11'd431,  11'd433,  11'd439,  11'd443,  11'd449,  11'd457,
      11'd461,  11'd463,  11'd467,  11'd479,  11'd487,  11'd491,  11'd499,  11'd503,
      11'd509,  11'd521,  11'd523,  11'd541,  11'd547,  11'd557,  11'd563,  11'd569,
      11'd571,  11'd577,  11'd587,  11'd593,  11'd599,  11'd601,  11'd607,  11'd613,
      11'd617,  11'd619,  11'd631,  11'd641,  11'd643,  11'd647,  11'd653,  11'd659,
      11'd661,  11'd673,  11'd677,  11'd683,  11'd691,  11'd701,  11'd709,  11'd719,
      11'd727,  11'd733,  11'd739,  11'd743,  11'd751,  11'd757,  11'd761,  11'd769,
      11'd773,  11'd787,  11'd797,  11'd809,  11'd811,  11'd821,  11'd823,  11'd827,
      11'd829,  11'd839,  11'd853,  11'd857,  11'd859,  11'd863,  11'd877,  11'd881,
      11'd883,  11'd887,  11'd907,  11'd911,  11'd919,  11'd929,  11'd937,  11'd941,
      11'd947,  11'd953,  11'd967,  11'd971,  11'd977,  11'd983,  11'd991,  11'd997,
      11'd1009, 11'd1013, 11'd1019, 11'd1021
   };

   // zero past the last prime
   function automatic logic [VALUE_WIDTH-1:0] prime_at(input logic [SLOT_WIDTH-1:0] slot);
      logic [VALUE_WIDTH-1:0] p;
      p = '0;
      if (slot < SLOT_WIDTH'(PRIME_SLOTS)) p = PRIME_TABLE[slot];
      return p;
   endfunction

endpackage
`default_nettype wire

// File: hdl/pera_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pera_ctrl: sequencer
// walks the prime table, drives the shared divider and the exponent store
// -----------------------------------------------------------------------------
module pera_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire pera_pkg::dp_stat_type stat,
   output pera_pkg::dp_cmd_type      cmd
);
   import pera_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           is_fact;

   assign is_fact = (stat.op == OP_MUL_FACT) || (stat.op == OP_DIV_FACT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status_code = ST_OK;
      cmd.div_src     = SRC_VALUE;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (stat.op inside {OP_MUL, OP_DIV, OP_MUL_FACT, OP_DIV_FACT}) begin
               if (stat.zero_flag) begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = ST_IGNORED;
               end else if (!is_fact && stat.power_zero) begin
                  state_in = S_DONE;
               end else if (stat.over_bound) begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = ST_BOUND;
               end else if (stat.op == OP_MUL && stat.value_zero) begin
                  cmd.clear_store = 1'b1;
                  cmd.set_zero    = 1'b1;
               end else begin
                  cmd.item_start = 1'b1;
                  state_in       = S_PRIME;
               end
            end else if (stat.op == OP_CLEAR) begin
               cmd.clear_store = 1'b1;
               cmd.clear_zero  = 1'b1;
            end else if (stat.op == OP_READ) begin
               if (stat.read_in_range) begin
                  state_in = S_READ;
               end else begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = ST_BOUND;
               end
            end
         end
         S_PRIME: begin
            if (stat.slot_end || (is_fact ? stat.prime_gt_value : stat.work_le1)) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = is_fact ? SRC_VALUE : SRC_WORK;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               if (is_fact) begin
                  cmd.div_take = 1'b1;
                  if (stat.quot_ge_p) begin
                     cmd.div_start = 1'b1;
                     cmd.div_src   = SRC_QUOT;
                  end else begin
                     state_in = S_ACC;
                  end
               end else if (stat.rem_zero) begin
                  cmd.div_take  = 1'b1;
                  cmd.div_start = 1'b1;
                  cmd.div_src   = SRC_QUOT;
               end else begin
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            if (stat.m_zero) begin
               cmd.next_prime = 1'b1;
               state_in       = S_PRIME;
            end else begin
               cmd.acc_read = 1'b1;
               state_in     = S_ACC_WR;
            end
         end
         S_ACC_WR: begin
            cmd.acc_write  = 1'b1;
            cmd.next_prime = 1'b1;
            state_in       = S_PRIME;
         end
         S_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hdl/pera_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pera_dp: datapath
// item registers, radix-2 divider, exponent store and output register
// -----------------------------------------------------------------------------
module pera_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pera_pkg::req_word_type req_word,
   input  wire pera_pkg::dp_cmd_type  cmd,
   output pera_pkg::dp_stat_type      stat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pera_pkg::rsp_word_type     rsp_word
);
   import pera_pkg::*;

   req_word_type               item_ff;
   logic                       zero_ff;
   rsp_status_type             status_ff;
   logic [COUNT_WIDTH-1:0]     slot_ff;
   logic [VALUE_WIDTH-1:0]     work_ff;
   logic [M_WIDTH-1:0]         m_ff;
   logic [REM_WIDTH-1:0]       div_rem_ff;
   logic [VALUE_WIDTH-1:0]     div_quo_ff;
   logic [DIV_CNT_WIDTH-1:0]   div_cnt_ff;
   logic [DELTA_WIDTH-1:0]     delta_ff;
   logic signed [EXP_WIDTH-1:0] rd_data_ff;
   logic                       rd_valid_ff;
   logic [PRIME_SLOTS-1:0]     valid_ff;
   logic signed [EXP_WIDTH-1:0] store_mem [PRIME_SLOTS];
   logic                       rsp_valid_ff;
   rsp_word_type               rsp_ff, rsp_in;

   logic [SLOT_WIDTH-1:0]      slot_idx;
   logic [SLOT_WIDTH-1:0]      rd_addr;
   logic [VALUE_WIDTH-1:0]     cur_prime;
   logic [VALUE_WIDTH-1:0]     div_shift;
   logic [VALUE_WIDTH-1:0]     div_diff;
   logic                       div_ge;
   logic [VALUE_WIDTH-1:0]     div_src_val;
   logic                       is_fact;
   logic                       is_neg;
   logic [POWER_WIDTH-1:0]     factor;
   logic [DELTA_WIDTH-1:0]     prod;
   logic signed [EXP_WIDTH-1:0] cur_exp;
   logic signed [EXP_WIDTH:0]  delta_s;
   logic signed [EXP_WIDTH:0]  sum;
   logic                       sat_hi;
   logic                       sat_lo;
   logic signed [EXP_WIDTH-1:0] wr_data;
   logic                       read_ok;

   assign slot_idx  = slot_ff[SLOT_WIDTH-1:0];
   assign cur_prime = prime_at(slot_idx);
   assign is_fact   = (item_ff.op == OP_MUL_FACT) || (item_ff.op == OP_DIV_FACT);
   assign is_neg    = (item_ff.op == OP_DIV) || (item_ff.op == OP_DIV_FACT);
   assign read_ok   = (item_ff.op == OP_READ) && stat.read_in_range;

   // one quotient bit per cycle, remainder stays below the prime
   assign div_shift = {div_rem_ff, div_quo_ff[VALUE_WIDTH-1]};
   assign div_ge    = div_shift >= cur_prime;
   assign div_diff  = div_shift - cur_prime;

   always_comb begin
      case (cmd.div_src)
         SRC_VALUE: div_src_val = item_ff.value;
         SRC_WORK:  div_src_val = work_ff;
         SRC_QUOT:  div_src_val = div_quo_ff;
         default:   div_src_val = div_quo_ff;
      endcase
   end

   // factorial sums add the count itself
   assign factor = is_fact ? POWER_WIDTH'(1) : item_ff.power;
   assign prod   = {{POWER_WIDTH{1'b0}}, m_ff} * {{M_WIDTH{1'b0}}, factor};

   // saturating read-modify-write
   assign cur_exp = rd_valid_ff ? rd_data_ff : '0;
   assign delta_s = is_neg ? -$signed({{(EXP_WIDTH+1-DELTA_WIDTH){1'b0}}, delta_ff})
                           :  $signed({{(EXP_WIDTH+1-DELTA_WIDTH){1'b0}}, delta_ff});
   assign sum     = {cur_exp[EXP_WIDTH-1], cur_exp} + delta_s;
   assign sat_hi  = !sum[EXP_WIDTH] && sum[EXP_WIDTH-1];
   assign sat_lo  = sum[EXP_WIDTH] && !sum[EXP_WIDTH-1];

   always_comb begin
      if (sat_hi) begin
         wr_data = {1'b0, {(EXP_WIDTH-1){1'b1}}};
      end else if (sat_lo) begin
         wr_data = {1'b1, {(EXP_WIDTH-1){1'b0}}};
      end else begin
         wr_data = sum[EXP_WIDTH-1:0];
      end
   end

   assign rd_addr = cmd.read_issue ? item_ff.value[SLOT_WIDTH-1:0] : slot_idx;

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_word;
      if (cmd.item_start) begin
         slot_ff <= '0;
         work_ff <= item_ff.value;
      end else if (cmd.next_prime) begin
         slot_ff <= slot_ff + COUNT_WIDTH'(1);
      end
      if (cmd.div_take) begin
         if (is_fact) begin
            m_ff <= m_ff + div_quo_ff;
         end else begin
            work_ff <= div_quo_ff;
            m_ff    <= m_ff + M_WIDTH'(1);
         end
      end else if (cmd.div_start && cmd.div_src != SRC_QUOT) begin
         // new prime starts its count at zero
         m_ff <= '0;
      end
      if (cmd.div_start) begin
         div_rem_ff <= '0;
         div_quo_ff <= div_src_val;
      end else if (div_cnt_ff != '0) begin
         div_rem_ff <= div_ge ? div_diff[REM_WIDTH-1:0] : div_shift[REM_WIDTH-1:0];
         div_quo_ff <= {div_quo_ff[VALUE_WIDTH-2:0], div_ge};
      end
      if (cmd.acc_read) delta_ff <= prod;
      if (cmd.acc_read || cmd.read_issue) begin
         rd_data_ff  <= store_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.acc_write) store_mem[slot_idx] <= wr_data;
      if (cmd.out_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff   <= '0;
         zero_ff      <= 1'b0;
         status_ff    <= ST_OK;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.div_start) begin
            div_cnt_ff <= DIV_CNT_WIDTH'(DIV_STEPS);
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - DIV_CNT_WIDTH'(1);
         end
         if (cmd.set_zero) begin
            zero_ff <= 1'b1;
         end else if (cmd.clear_zero) begin
            zero_ff <= 1'b0;
         end
         if (cmd.load_item) begin
            status_ff <= ST_OK;
         end else if (cmd.status_load) begin
            status_ff <= cmd.status_code;
         end else if (cmd.acc_write && (sat_hi || sat_lo)) begin
            status_ff <= ST_SAT;
         end
         if (cmd.clear_store) begin
            valid_ff <= '0;
         end else if (cmd.acc_write) begin
            valid_ff[slot_idx] <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.prime        = read_ok ? prime_at(item_ff.value[SLOT_WIDTH-1:0]) : '0;
      rsp_in.net_exponent = (read_ok && rd_valid_ff) ? rd_data_ff : '0;
      rsp_in.is_zero      = zero_ff;
      rsp_in.status       = status_ff;
   end

   always_comb begin
      stat                = '0;
      stat.op             = item_ff.op;
      stat.zero_flag      = zero_ff;
      stat.power_zero     = (item_ff.power == '0);
      stat.value_zero     = (item_ff.value == '0);
      stat.over_bound     = (item_ff.value > VALUE_WIDTH'(MAX_VALUE));
      stat.read_in_range  = (item_ff.value < VALUE_WIDTH'(PRIME_SLOTS));
      stat.slot_end       = (slot_ff == COUNT_WIDTH'(PRIME_SLOTS));
      stat.work_le1       = (work_ff <= VALUE_WIDTH'(1));
      stat.prime_gt_value = (cur_prime > item_ff.value);
      stat.div_done       = (div_cnt_ff == '0);
      stat.rem_zero       = (div_rem_ff == '0);
      stat.quot_ge_p      = (div_quo_ff >= cur_prime);
      stat.m_zero         = (m_ff == '0);
      stat.out_free       = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

// File: hdl/prime_exponent_ratio_accumulator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// prime_exponent_ratio_accumulator_top: prime exponent ratio accumulator
// holds a rational number as one saturating signed exponent per prime <= 1024
// -----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req_word) takes one word per item:
//   multiply, divide, multiply factorial, divide factorial, clear or read.
//   rsp channel (rsp_valid / rsp_stall / rsp_word) returns one word per item.
//   one item is worked at a time; req_stall is low only while idle.
//   the response word is loaded from the done state, after decode for clear,
//   unused codes and rejected updates and after a read state for read; the next
//   item can be taken once its response is loaded. each step of the prime walk
//   runs through one shared radix-2 divider. worst case, the factorial of
//   1024 visits all 172 primes with 198 divisions.
//   the response sits in an output register; a new item is accepted while it
//   waits, and an item that finishes then holds until the register frees.
//   a stalled response holds its word unchanged.
//   reset: exponents read as zero (per-slot valid bits cleared), zero flag
//   cleared, no response pending. clear also clears the valid bits and zero flag.
// -----------------------------------------------------------------------------
module prime_exponent_ratio_accumulator_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pera_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pera_pkg::rsp_word_type     rsp_word
);
   import pera_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: decode, prime walk, divider handshake, response hand-off
   pera_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: divider, exponent store with valid bits, output register
   pera_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

// File: hdl/pera_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pera_checker: port checks
// response behavior seen at the top level ports
// -----------------------------------------------------------------------------
module pera_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire pera_pkg::rsp_word_type rsp_word
);
   import pera_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed under stall");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an ignored update means the zero flag is set
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_IGNORED |-> rsp_word.is_zero)
      else $error("ignored status without zero flag");

   // an exponent is only reported with its prime and an ok status
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.net_exponent != 0 |->
         rsp_word.prime != 0 && rsp_word.status == ST_OK)
      else $error("exponent without a valid read");

endmodule

bind prime_exponent_ratio_accumulator_top pera_checker u_pera_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
`default_nettype wire

// File: verif/prime_exponent_ratio_accumulator_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prime_exponent_ratio_accumulator_top_tb: self-checking bench for the accumulator
// drives update, clear and read words under random idling and long receive
// hold-offs, predicts every response word from a private exponent model and
// compares each returned word field by field in order
// -----------------------------------------------------------------------------
module prime_exponent_ratio_accumulator_top_tb;
   import pera_pkg::*;

   localparam int  LIMIT_CYCLES = 8_000_000;
   localparam int  N_PRIMES     = 172;
   localparam int  N_RANDOM     = 525;
   localparam int  SAT_STEPS    = 8;
   localparam longint EXP_HI    = 64'sd2147483647;
   localparam longint EXP_LO    = -64'sd2147483648;

   // exponent model plus queue of response words still owed by the block
   class ratio_scoreboard;
      longint       net_exp [N_PRIMES];
      bit           zero_held;
      int unsigned  primes [N_PRIMES];
      rsp_word_type owed [$];
      int           errors;

      function new();
         int unsigned n, cnt;
         bit is_p;
         cnt = 0;
         for (n = 2; n <= MAX_VALUE && cnt < N_PRIMES; n++) begin
            is_p = 1;
            for (int k = 0; k < cnt; k++) begin
               if (n % primes[k] == 0) is_p = 0;
            end
            if (is_p) begin
               primes[cnt] = n;
               cnt++;
            end
         end
         wipe();
         zero_held = 0;
         errors = 0;
      endfunction

      function void wipe();
         foreach (net_exp[i]) net_exp[i] = 0;
      endfunction

      // saturating add, returns 1 when the slot clamps
      function bit bump(int i, longint d);
         longint e;
         e = net_exp[i] + d;
         if (e > EXP_HI) begin
            net_exp[i] = EXP_HI;
            return 1;
         end
         if (e < EXP_LO) begin
            net_exp[i] = EXP_LO;
            return 1;
         end
         net_exp[i] = e;
         return 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void note(req_word_type w);
         rsp_word_type r;
         rsp_status_type st;
         bit clamp;
         int unsigned v, q, p;
         longint m;
         st = ST_OK;
         clamp = 0;
         r = '0;
         v = w.value;
         if (w.op <= OP_DIV_FACT) begin
            if (zero_held) st = ST_IGNORED;
            else if ((w.op == OP_MUL || w.op == OP_DIV) && w.power == 0) st = ST_OK;
            else if (v > MAX_VALUE) st = ST_BOUND;
            else if (w.op == OP_MUL && v == 0) begin
               wipe();
               zero_held = 1;
            end else if (w.op == OP_MUL || w.op == OP_DIV) begin
               for (int i = 0; i < N_PRIMES && v > 1; i++) begin
                  p = primes[i];
                  m = 0;
                  while (v % p == 0) begin
                     v = v / p;
                     m++;
                  end
                  if (m != 0) begin
                     m = m * longint'(w.power);
                     if (bump(i, (w.op == OP_MUL) ? m : -m)) clamp = 1;
                  end
               end
            end else begin
               for (int i = 0; i < N_PRIMES && primes[i] <= v; i++) begin
                  p = primes[i];
                  q = v;
                  m = 0;
                  while (q >= p) begin
                     q = q / p;
                     m += q;
                  end
                  if (bump(i, (w.op == OP_MUL_FACT) ? m : -m)) clamp = 1;
               end
            end
            if (clamp) st = ST_SAT;
         end else if (w.op == OP_CLEAR) begin
            wipe();
            zero_held = 0;
         end else if (w.op == OP_READ) begin
            if (v < N_PRIMES) begin
               r.prime = primes[v];
               r.net_exponent = net_exp[v][31:0];
            end else st = ST_BOUND;
         end
         r.is_zero = zero_held;
         r.status = st;
         owed.insert(owed.size(), r);
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type exp_w;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected response word %h", got);
            return;
         end
         exp_w = owed.pop_front();
         if (got.prime !== exp_w.prime || got.net_exponent !== exp_w.net_exponent ||
             got.is_zero !== exp_w.is_zero || got.status !== exp_w.status) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: prime %0d/%0d net %0d/%0d zero %0d/%0d status %0d/%0d (exp/act)",
                        exp_w.prime, got.prime, exp_w.net_exponent, got.net_exponent,
                        exp_w.is_zero, got.is_zero, exp_w.status, got.status);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   ratio_scoreboard sb = new();
   int send_idle_pct = 15;
   int recv_idle_pct = 58;
   int hold_cycles   = 0;
   int unsigned cycle_count = 0;

   prime_exponent_ratio_accumulator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL prime_exponent_ratio_accumulator_top");
         $finish;
      end
   end

   // receiver: a long hold-off wins over random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // response monitor, samples pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_word);
   end

   // offer one word, optionally after a gap, and hold it until accepted
   task automatic send_word(input logic [2:0] op, input int unsigned value,
                            input int unsigned power);
      req_word_type w;
      w.op = op;
      w.value = value[VALUE_WIDTH-1:0];
      w.power = power[POWER_WIDTH-1:0];
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note(w);
   endtask

   // lower valid and wait until every owed word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // one random item, mostly small values so the prime walk stays short
   task automatic send_random();
      int unsigned sel, op, value, power;
      sel = $urandom_range(99);
      if (sel < 25) op = OP_MUL;
      else if (sel < 45) op = OP_DIV;
      else if (sel < 56) op = OP_MUL_FACT;
      else if (sel < 67) op = OP_DIV_FACT;
      else if (sel < 72) op = OP_CLEAR;
      else if (sel < 97) op = OP_READ;
      else op = $urandom_range(6, 7);
      sel = $urandom_range(99);
      if (op == OP_READ) begin
         value = (sel < 85) ? $urandom_range(0, 20) :
                 (sel < 95) ? $urandom_range(0, N_PRIMES - 1) : $urandom_range(0, 2047);
      end else if (op == OP_MUL_FACT || op == OP_DIV_FACT) begin
         value = (sel < 85) ? $urandom_range(0, 40) :
                 (sel < 95) ? $urandom_range(0, 300) : $urandom_range(0, 2047);
      end else begin
         // multiply by zero is kept rare so the sticky flag does not dominate
         value = (sel < 3) ? 0 : (sel < 75) ? $urandom_range(1, 64) :
                 (sel < 93) ? $urandom_range(1, MAX_VALUE) : $urandom_range(0, 2047);
      end
      sel = $urandom_range(99);
      power = (sel < 10) ? 0 : (sel < 70) ? $urandom_range(1, 9) : $urandom_range(0, 65535);
      send_word(op[2:0], value, power);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each op and the corner cases
      send_word(OP_MUL, 1, 0);             // power zero
      send_word(OP_MUL, 12, 3);
      send_word(OP_DIV, 1024, 65535);
      send_word(OP_MUL_FACT, 1024, 0);     // longest walk
      send_word(OP_DIV_FACT, 0, 0);
      send_word(OP_MUL_FACT, 1, 0);
      send_word(OP_MUL, 1, 7);             // one
      send_word(OP_READ, 0, 0);
      send_word(OP_READ, N_PRIMES - 1, 65535);
      send_word(OP_READ, N_PRIMES, 0);     // index past the table
      send_word(OP_READ, 2047, 0);
      send_word(OP_MUL, 1025, 1);          // above bound
      send_word(OP_DIV_FACT, 2047, 1);
      send_word(3'd6, 5, 5);               // unused codes
      send_word(3'd7, 2047, 65535);
      send_word(OP_DIV, 0, 5);             // divide by zero leaves the exponents unchanged
      send_word(OP_MUL, 0, 1);             // sticky zero
      send_word(OP_MUL, 5, 2);
      send_word(OP_MUL_FACT, 3, 0);
      send_word(OP_READ, 1, 0);
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_DIV_FACT, 10, 0);
      send_word(OP_MUL, 1021, 65535);
      send_word(OP_READ, N_PRIMES - 1, 0);
      send_word(OP_READ, 3, 0);

      // receiver holds off long while words keep coming, so the input stalls
      hold_cycles = 3000;
      repeat (6) send_random();
      // sender pause until everything is back
      drain();

      for (int i = 0; i < N_RANDOM / 3; i++) send_random();
      drain();
      send_idle_pct = 58;
      recv_idle_pct = 15;
      for (int i = 0; i < N_RANDOM / 3; i++) send_random();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < N_RANDOM / 3; i++) send_random();

      // large steps on the exponent of two, up and then well below zero
      send_word(OP_CLEAR, 0, 0);
      for (int i = 0; i < SAT_STEPS; i++) send_word(OP_MUL, 1024, 65535);
      send_word(OP_READ, 0, 0);
      for (int i = 0; i < 2 * SAT_STEPS; i++) send_word(OP_DIV, 1024, 65535);
      send_word(OP_READ, 0, 0);
      send_word(OP_DIV_FACT, 4, 0);
      send_word(OP_READ, 0, 0);

      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS prime_exponent_ratio_accumulator_top");
      end else begin
         $display("FAIL prime_exponent_ratio_accumulator_top");
      end
      $finish;
   end

endmodule
